FILE: hdl/dqpi_pkg.sv
// Shared types and codes for the double-ended queue with positional insert.
package dqpi_pkg;

  // Operation codes carried in the input transfer.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_INSERT     = 3'd4
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // What every cell of the chain does.
  typedef enum logic [1:0] {
    CM_HOLD      = 2'd0,
    CM_INSERT    = 2'd1,
    CM_SHIFT_FWD = 2'd2
  } cell_mode_e;

  localparam int unsigned OpWidth      = 3;
  localparam int unsigned PosWidth     = 8;
  localparam int unsigned PayloadWidth = 32;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned RemovedWidth = 32;
  localparam int unsigned CountWidth   = 5;
  localparam int unsigned InDataWidth  = 48;
  localparam int unsigned OutDataWidth = 40;

endpackage

FILE: hdl/dqpi_cell.sv
// One storage cell of the queue chain: hold, load the new word, or take a neighbor's word.
module dqpi_cell #(
  parameter int unsigned ITEM_WIDTH = 32,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                    clk_i,
  input  dqpi_pkg::cell_mode_e    mode_i,
  input  logic [IDX_W-1:0]        ins_idx_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic [ITEM_WIDTH-1:0]   word_i,
  input  logic [ITEM_WIDTH-1:0]   left_i,
  input  logic [ITEM_WIDTH-1:0]   right_i,
  output logic [ITEM_WIDTH-1:0]   data_o,
  output logic [ITEM_WIDTH-1:0]   rear_o
);

  logic [ITEM_WIDTH-1:0] data_q, data_d;
  logic                  at_idx, past_idx, is_rear;

  assign at_idx   = (ins_idx_i == IDX_W'(CELL_IDX));
  assign past_idx = (IDX_W'(CELL_IDX) > ins_idx_i);
  assign is_rear  = (count_i == CNT_W'(CELL_IDX + 1));

  always_comb begin
    data_d = data_q;
    unique case (mode_i)
      dqpi_pkg::CM_HOLD: begin
        data_d = data_q;
      end
      dqpi_pkg::CM_INSERT: begin
        // the cell at the insert point loads the new word; cells behind it move back by one
        if (at_idx) begin
          data_d = word_i;
        end else if (past_idx) begin
          data_d = left_i;
        end
      end
      dqpi_pkg::CM_SHIFT_FWD: begin
        data_d = right_i;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rear_o = is_rear ? data_q : '0;

endmodule

FILE: hdl/deque_with_positional_insert.sv
// Top level of the double-ended queue with positional insert.
//
// A bounded ordered list of DEPTH task words kept in a chain of cells, slot 0
// at the front. Each input transfer carries one operation: push front, push
// rear, pop front, pop rear, or insert at a 1-based position (entries from that
// position on move back by one). Every operation yields exactly one result
// transfer with a status (ok, underflow, position out of range, full), the word
// removed by a successful pop (zero otherwise), the entry count after the
// operation and an empty flag. An out-of-range position is reported ahead of a
// full store; unused operation codes leave everything as it is and report ok.
// Rate: one operation per cycle unless the result stream stalls. Every cell
// decides on its own whether to hold, load the new word or take a neighbor's
// word, so a whole insert or pop finishes in the cycle the input transfer is
// accepted; the result appears in the output register on the next cycle. The
// input is ready whenever the output register is empty or is being taken in
// the same cycle. Stored words have no reset; only the count and valid flag do.
module deque_with_positional_insert #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0 up: op[2:0], position[10:3], payload[42:11], zero fill
  input  logic [dqpi_pkg::InDataWidth-1:0]    s_axis_tdata,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0 up: status[1:0], removed_item[33:2], entry_count[38:34],
  // is_empty[39]
  output logic [dqpi_pkg::OutDataWidth-1:0]   m_axis_tdata
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // wide enough for position and for count + 1
  localparam int unsigned CMP_W = ((CNT_W > dqpi_pkg::PosWidth) ? CNT_W
                                                                : dqpi_pkg::PosWidth) + 1;

  // Unpack the input transfer.
  logic [dqpi_pkg::OpWidth-1:0]      in_op;
  logic [dqpi_pkg::PosWidth-1:0]     in_pos;
  logic [dqpi_pkg::PayloadWidth-1:0] in_payload;
  logic                              in_fire;

  assign in_op      = s_axis_tdata[2:0];
  assign in_pos     = s_axis_tdata[10:3];
  assign in_payload = s_axis_tdata[42:11];

  // Output register acts as the skid between the two sides.
  logic                                  out_valid_q;
  logic [dqpi_pkg::StatusWidth-1:0]      out_status_q;
  logic [dqpi_pkg::RemovedWidth-1:0]     out_removed_q;
  logic [dqpi_pkg::CountWidth-1:0]       out_count_q;
  logic                                  out_empty_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Entry count.
  logic [CNT_W-1:0] count_q, count_d;

  // Store word, kept to ITEM_WIDTH bits.
  logic [63:0]           payload_ext;
  logic [ITEM_WIDTH-1:0] word;

  assign payload_ext = 64'(in_payload);
  assign word        = payload_ext[ITEM_WIDTH-1:0];

  // Checks against the current count.
  logic             is_full, is_none, pos_bad;
  logic [CMP_W-1:0] pos_ext, lim_ext;

  assign is_full = (count_q == CNT_W'(DEPTH));
  assign is_none = (count_q == '0);
  assign pos_ext = CMP_W'(in_pos);
  assign lim_ext = CMP_W'(count_q) + CMP_W'(1);
  assign pos_bad = (pos_ext == '0) || (pos_ext > lim_ext);

  // Cell chain wiring.
  logic [ITEM_WIDTH-1:0]  cell_data [DEPTH];
  logic [ITEM_WIDTH-1:0]  cell_rear [DEPTH];
  logic [ITEM_WIDTH-1:0]  rear_word;
  dqpi_pkg::cell_mode_e   mode;
  logic [IDX_W-1:0]       ins_idx;

  // Decode the operation: cell mode, insert slot, status, removed word and count.
  dqpi_pkg::status_e              status;
  logic [ITEM_WIDTH-1:0]          removed_raw;
  logic [63:0]                    removed_ext;
  logic [CMP_W-1:0]               pos_less1;

  assign pos_less1 = pos_ext - CMP_W'(1);

  always_comb begin
    mode        = dqpi_pkg::CM_HOLD;
    ins_idx     = '0;
    status      = dqpi_pkg::ST_OK;
    removed_raw = '0;
    count_d     = count_q;
    unique case (in_op)
      dqpi_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          status = dqpi_pkg::ST_FULL;
        end else begin
          mode    = dqpi_pkg::CM_INSERT;
          ins_idx = '0;
          count_d = count_q + CNT_W'(1);
        end
      end
      dqpi_pkg::OP_PUSH_REAR: begin
        if (is_full) begin
          status = dqpi_pkg::ST_FULL;
        end else begin
          mode    = dqpi_pkg::CM_INSERT;
          ins_idx = IDX_W'(count_q);
          count_d = count_q + CNT_W'(1);
        end
      end
      dqpi_pkg::OP_POP_FRONT: begin
        if (is_none) begin
          status = dqpi_pkg::ST_UNDERFLOW;
        end else begin
          // advance every cell toward the front
          mode        = dqpi_pkg::CM_SHIFT_FWD;
          removed_raw = cell_data[0];
          count_d     = count_q - CNT_W'(1);
        end
      end
      dqpi_pkg::OP_POP_REAR: begin
        if (is_none) begin
          status = dqpi_pkg::ST_UNDERFLOW;
        end else begin
          removed_raw = rear_word;
          count_d     = count_q - CNT_W'(1);
        end
      end
      dqpi_pkg::OP_INSERT: begin
        if (pos_bad) begin
          status = dqpi_pkg::ST_RANGE;
        end else if (is_full) begin
          status = dqpi_pkg::ST_FULL;
        end else begin
          mode    = dqpi_pkg::CM_INSERT;
          ins_idx = pos_less1[IDX_W-1:0];
          count_d = count_q + CNT_W'(1);
        end
      end
      default: begin
        // unused codes: leave everything as it is
        status = dqpi_pkg::ST_OK;
      end
    endcase
  end

  assign removed_ext = 64'(removed_raw);

  // Gate cell activity with the input transfer.
  dqpi_pkg::cell_mode_e cell_mode;
  assign cell_mode = in_fire ? mode : dqpi_pkg::CM_HOLD;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [ITEM_WIDTH-1:0] left_w, right_w;
      if (gi == 0) begin : g_first
        assign left_w = cell_data[gi];
      end else begin : g_mid_l
        assign left_w = cell_data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_w = cell_data[gi];
      end else begin : g_mid_r
        assign right_w = cell_data[gi+1];
      end

      dqpi_cell #(
        .ITEM_WIDTH (ITEM_WIDTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W),
        .CELL_IDX   (gi)
      ) u_cell (
        .clk_i     (clk_i),
        .mode_i    (cell_mode),
        .ins_idx_i (ins_idx),
        .count_i   (count_q),
        .word_i    (word),
        .left_i    (left_w),
        .right_i   (right_w),
        .data_o    (cell_data[gi]),
        .rear_o    (cell_rear[gi])
      );
    end
  endgenerate

  // Only the rear cell drives a nonzero word; OR them together.
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | cell_rear[i];
    end
  end

  // Count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_fire) begin
      count_q <= count_d;
    end
  end

  // Result register: load on an input transfer, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_status_q  <= status;
      out_removed_q <= removed_ext[dqpi_pkg::RemovedWidth-1:0];
      out_count_q   <= dqpi_pkg::CountWidth'(count_d);
      out_empty_q   <= (count_d == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_empty_q, out_count_q, out_removed_q, out_status_q};

endmodule
